### rtl/sdc_pkg.sv
// Shared types, codes and field layout for the subnet distance classifier.
package sdc_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int INDEX_W  = 4;
    localparam int HALF_W   = 64;
    localparam int IPV4_W   = 32;
    localparam int DIST_W   = 2;

    // s_axis_tdata layout, lowest bit first
    localparam int OP_LSB      = 0;
    localparam int IDX_LSB     = 1;
    localparam int PRESENT_LSB = IDX_LSB + INDEX_W;
    localparam int FAMILY_LSB  = PRESENT_LSB + 1;
    localparam int AHI_LSB     = FAMILY_LSB + 1;
    localparam int ALO_LSB     = AHI_LSB + HALF_W;
    localparam int MHI_LSB     = ALO_LSB + HALF_W;
    localparam int MLO_LSB     = MHI_LSB + HALF_W;
    localparam int S_FIELDS_W  = MLO_LSB + HALF_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = 8;

    // RAM word: family, addr high, addr low, mask high, mask low
    localparam int ENTRY_W = 1 + 4 * HALF_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic FAMILY_IPV4 = 1'b0;
    localparam logic FAMILY_IPV6 = 1'b1;

    typedef enum logic [DIST_W-1:0] {
        DIST_LOOPBACK = 2'd0,
        DIST_DIRECT   = 2'd1,
        DIST_ROUTED   = 2'd2
    } dist_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic write_entry;
        logic start_query;
        logic walk;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_is_query;
        logic last_slot;
        logic out_free;
    } status_t;

endpackage

### rtl/subnet_distance_classifier_top.sv
// Top level of the subnet distance classifier.
//
//  channel | dir | word fields (lowest bit first)
//  --------+-----+---------------------------------------------------------------
//  s_axis  | in  | operation, entry_index, entry_present, addr_family,
//          |     | addr_high, addr_low, mask_high, mask_low
//  m_axis  | out | distance (one word per query, none per write)
//
// A write word is taken at once and s_axis_tready stays high.
// A query reads the entry RAM one slot per cycle through the single read port, then
// passes ST_FLUSH and ST_EMIT; m_axis_tvalid rises from the output register after
// ST_EMIT, and the next word is taken only once the sequencer is back in ST_IDLE.
// Reset clears the slot valid bits at once; no sweep is needed.
// A result waiting on m_axis_tready does not block writes; a following query
// stalls only at its own handoff into the output register.
module subnet_distance_classifier_top #(
    parameter int TABLE_ENTRIES = sdc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // operation, entry_index, entry_present, addr_family, addr_high, addr_low,
    // mask_high, mask_low
    input  logic [sdc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // distance
    output logic [sdc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import sdc_pkg::*;

    cmd_t    cmd;
    status_t status;

    sdc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    sdc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

### rtl/sdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/sdc_ctrl.sv
// Sequencer: accepts words, walks the table for queries, hands off results.
module sdc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  sdc_pkg::status_t status,
    output sdc_pkg::cmd_t   cmd
);
    import sdc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (status.in_is_query) begin
                        cmd.start_query = 1'b1;
                        state_next      = ST_WALK;
                    end else begin
                        cmd.write_entry = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (status.last_slot) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/sdc_datapath.sv
// Entry table, slot walk counter, match compare and result register.
module sdc_datapath #(
    parameter int TABLE_ENTRIES = sdc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [sdc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [sdc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  sdc_pkg::cmd_t                 cmd,
    output sdc_pkg::status_t              status
);
    import sdc_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [INDEX_W-1:0] in_idx;
    logic               in_present;
    logic               in_family;
    logic [HALF_W-1:0]  in_ahi;
    logic [HALF_W-1:0]  in_alo;
    logic [HALF_W-1:0]  in_mhi;
    logic [HALF_W-1:0]  in_mlo;
    logic               in_range;
    logic [AW-1:0]      wr_addr;

    assign in_idx     = s_axis_tdata[IDX_LSB +: INDEX_W];
    assign in_present = s_axis_tdata[PRESENT_LSB];
    assign in_family  = s_axis_tdata[FAMILY_LSB];
    assign in_ahi     = s_axis_tdata[AHI_LSB +: HALF_W];
    assign in_alo     = s_axis_tdata[ALO_LSB +: HALF_W];
    assign in_mhi     = s_axis_tdata[MHI_LSB +: HALF_W];
    assign in_mlo     = s_axis_tdata[MLO_LSB +: HALF_W];
    assign in_range   = (32'(in_idx) < 32'(TABLE_ENTRIES));
    assign wr_addr    = AW'(in_idx);

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [AW-1:0]            slot_reg;
    logic                     pend_reg;
    logic                     qfam_reg;
    logic [HALF_W-1:0]        qhi_reg;
    logic [HALF_W-1:0]        qlo_reg;
    logic                     loop_reg;
    logic                     direct_reg;
    logic                     out_valid_reg;
    logic [DIST_W-1:0]        out_dist_reg;
    logic [ENTRY_W-1:0]       rd_data;

    sdc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.write_entry && in_present && in_range),
        .wr_addr (wr_addr),
        .wr_data ({in_family, in_ahi, in_alo, in_mhi, in_mlo}),
        .rd_en   (cmd.walk),
        .rd_addr (slot_reg),
        .rd_data (rd_data)
    );

    logic              e_family;
    logic [HALF_W-1:0] e_ahi;
    logic [HALF_W-1:0] e_alo;
    logic [HALF_W-1:0] e_mhi;
    logic [HALF_W-1:0] e_mlo;
    logic              fam_hit;
    logic              addr_eq;
    logic              net_eq;

    always_comb begin
        e_family = rd_data[4*HALF_W];
        e_ahi    = rd_data[3*HALF_W +: HALF_W];
        e_alo    = rd_data[2*HALF_W +: HALF_W];
        e_mhi    = rd_data[HALF_W +: HALF_W];
        e_mlo    = rd_data[0 +: HALF_W];
        if (qfam_reg == FAMILY_IPV4) begin
            e_ahi = '0;
            e_mhi = '0;
            e_alo = {{(HALF_W-IPV4_W){1'b0}}, e_alo[IPV4_W-1:0]};
            e_mlo = {{(HALF_W-IPV4_W){1'b0}}, e_mlo[IPV4_W-1:0]};
        end
        fam_hit = pend_reg && (e_family == qfam_reg);
        addr_eq = (e_ahi == qhi_reg) && (e_alo == qlo_reg);
        net_eq  = (((qhi_reg ^ e_ahi) & e_mhi) == '0) && (((qlo_reg ^ e_alo) & e_mlo) == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.write_entry && in_range) begin
                valid_reg[wr_addr] <= in_present;
            end
            pend_reg <= cmd.walk && valid_reg[slot_reg];
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_query) begin
            slot_reg   <= '0;
            loop_reg   <= 1'b0;
            direct_reg <= 1'b0;
            qfam_reg   <= in_family;
            if (in_family == FAMILY_IPV4) begin
                qhi_reg <= '0;
                qlo_reg <= {{(HALF_W-IPV4_W){1'b0}}, in_alo[IPV4_W-1:0]};
            end else begin
                qhi_reg <= in_ahi;
                qlo_reg <= in_alo;
            end
        end else begin
            if (cmd.walk) begin
                slot_reg <= slot_reg + AW'(1);
            end
            if (fam_hit && addr_eq) begin
                loop_reg <= 1'b1;
            end
            if (fam_hit && net_eq) begin
                direct_reg <= 1'b1;
            end
        end
        if (cmd.emit) begin
            priority if (loop_reg) begin
                out_dist_reg <= DIST_LOOPBACK;
            end else if (direct_reg) begin
                out_dist_reg <= DIST_DIRECT;
            end else begin
                out_dist_reg <= DIST_ROUTED;
            end
        end
    end

    assign status.in_is_query = (s_axis_tdata[OP_LSB] == OP_QUERY);
    assign status.last_slot   = (slot_reg == AW'(TABLE_ENTRIES - 1));
    assign status.out_free    = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-DIST_W){1'b0}}, out_dist_reg};

endmodule

### rtl/sdc_checker.sv
// Port-level checks for the subnet distance classifier, bound to the top.
module sdc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [sdc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [sdc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import sdc_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed under stall");

    a_dist_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((m_axis_tdata[DIST_W-1:0] == DIST_LOOPBACK)
                        || (m_axis_tdata[DIST_W-1:0] == DIST_DIRECT)
                        || (m_axis_tdata[DIST_W-1:0] == DIST_ROUTED)))
        else $error("bad distance code");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && (s_axis_tdata[OP_LSB] == OP_QUERY))
            |=> !s_axis_tready)
        else $error("input ready during table walk");

    a_write_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && (s_axis_tdata[OP_LSB] == OP_WRITE))
            |=> s_axis_tready)
        else $error("write word stalled the input");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && (s_axis_tdata[OP_LSB] == OP_QUERY)
            && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared right after query accept");

endmodule

bind subnet_distance_classifier_top sdc_checker u_sdc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
